### hdl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tokenizer assertion failed");
`define STT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");
`define STT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");
`else
`define STT_ASSERT(lbl, prop)
`define STT_ASSERT_IMP(lbl, ante, cons)
`define STT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hdl/stt_pkg.sv
// Types, character codes and classification functions for the source text tokenizer
package stt_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_INT  = 2'd1,
		MODE_ID   = 2'd2,
		MODE_STR  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		KIND_ID    = 4'd0,
		KIND_INT   = 4'd1,
		KIND_STR   = 4'd2,
		KIND_SEMI  = 4'd3,
		KIND_COMMA = 4'd4,
		KIND_EQ    = 4'd5,
		KIND_LPAR  = 4'd6,
		KIND_RPAR  = 4'd7,
		KIND_LBRC  = 4'd8,
		KIND_RBRC  = 4'd9,
		KIND_EOF   = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		CL_SKIP,
		CL_DIGIT,
		CL_LETTER,
		CL_QUOTE,
		CL_PUNCT
	} char_class_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       present;
		logic       last;
	} tok_item_t;

	// an accepted byte is queued only if it gives an item; it gives one or two items; first is always valid
	typedef struct packed {
		logic      second_vld;
		tok_item_t second;
		tok_item_t first;
	} tok_op_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cls;
		unique case (c) inside
			[CH_0:CH_9]:                cls = CL_DIGIT;
			[CH_UA:CH_UZ], [CH_LA:CH_LZ]: cls = CL_LETTER;
			CH_QUOTE:                   cls = CL_QUOTE;
			CH_SEMI, CH_COMMA, CH_EQ, CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC:
				cls = CL_PUNCT;
			default:                    cls = CL_SKIP;
		endcase
		return cls;
	endfunction

	function automatic kind_t punct_kind(input logic [7:0] c);
		kind_t k;
		unique case (c)
			CH_SEMI:  k = KIND_SEMI;
			CH_COMMA: k = KIND_COMMA;
			CH_EQ:    k = KIND_EQ;
			CH_LPAR:  k = KIND_LPAR;
			CH_RPAR:  k = KIND_RPAR;
			CH_LBRC:  k = KIND_LBRC;
			CH_RBRC:  k = KIND_RBRC;
			default:  k = KIND_EOF;
		endcase
		return k;
	endfunction

	function automatic kind_t mode_kind(input mode_t m);
		kind_t k;
		unique case (m)
			MODE_INT: k = KIND_INT;
			MODE_ID:  k = KIND_ID;
			default:  k = KIND_STR;
		endcase
		return k;
	endfunction

	function automatic tok_item_t mk_item(input kind_t kind, input logic [7:0] ch,
			input logic present, input logic last);
		tok_item_t it;
		it.kind    = kind;
		it.ch      = present ? ch : 8'h00;
		it.present = present;
		it.last    = last;
		return it;
	endfunction

endpackage

### hdl/stt_front.sv
// Front end: accepts text bytes, tracks the scan mode and builds the result items
module stt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            s_tuser,   // [0] cmd: end of text
	input  logic [7:0]      s_tdata,   // [7:0] text_byte
	input  logic            q_full,
	output logic            push,
	output stt_pkg::tok_op_t op
);
	import stt_pkg::*;

	mode_t       mode_q, mode_d, fresh_mode;
	char_class_t cls;
	tok_item_t   lead, tail;
	logic        lead_vld, tail_vld;
	tok_item_t   fresh;
	logic        fresh_vld;
	logic        accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign cls      = classify(s_tdata);

	// next scan mode
	always_comb begin
		fresh_mode = MODE_IDLE;
		unique case (cls)
			CL_DIGIT:  fresh_mode = MODE_INT;
			CL_LETTER: fresh_mode = MODE_ID;
			CL_QUOTE:  fresh_mode = MODE_STR;
			default: ;
		endcase
		mode_d = fresh_mode;
		if (s_tuser) begin
			mode_d = MODE_IDLE;
		end else begin
			unique case (mode_q)
				MODE_INT: begin
					if (cls == CL_DIGIT) begin
						mode_d = MODE_INT;
					end
				end
				MODE_ID: begin
					if (cls == CL_DIGIT || cls == CL_LETTER) begin
						mode_d = MODE_ID;
					end
				end
				MODE_STR: begin
					mode_d = (cls == CL_QUOTE) ? MODE_IDLE : MODE_STR;
				end
				default: ;
			endcase
		end
	end

	// item for a byte seen from idle
	always_comb begin
		fresh     = mk_item(KIND_ID, 8'h00, 1'b0, 1'b0);
		fresh_vld = 1'b0;
		unique case (cls)
			CL_DIGIT: begin
				fresh     = mk_item(KIND_INT, s_tdata, 1'b1, 1'b0);
				fresh_vld = 1'b1;
			end
			CL_LETTER: begin
				fresh     = mk_item(KIND_ID, s_tdata, 1'b1, 1'b0);
				fresh_vld = 1'b1;
			end
			CL_PUNCT: begin
				fresh     = mk_item(punct_kind(s_tdata), s_tdata, 1'b1, 1'b1);
				fresh_vld = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		lead     = mk_item(mode_kind(mode_q), 8'h00, 1'b0, 1'b1);
		lead_vld = 1'b0;
		tail     = fresh;
		tail_vld = fresh_vld;
		if (s_tuser) begin
			lead_vld = (mode_q != MODE_IDLE);
			tail     = mk_item(KIND_EOF, 8'h00, 1'b0, 1'b1);
			tail_vld = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_INT: begin
					lead_vld = 1'b1;
					if (cls == CL_DIGIT) begin
						lead     = mk_item(KIND_INT, s_tdata, 1'b1, 1'b0);
						tail_vld = 1'b0;
					end
				end
				MODE_ID: begin
					lead_vld = 1'b1;
					if (cls == CL_DIGIT || cls == CL_LETTER) begin
						lead     = mk_item(KIND_ID, s_tdata, 1'b1, 1'b0);
						tail_vld = 1'b0;
					end
				end
				MODE_STR: begin
					lead_vld = 1'b1;
					tail_vld = 1'b0;
					if (cls != CL_QUOTE) begin
						lead = mk_item(KIND_STR, s_tdata, 1'b1, 1'b0);
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (lead_vld) begin
			op.first      = lead;
			op.second     = tail;
			op.second_vld = tail_vld;
		end else begin
			op.first      = tail;
			op.second     = tail;
			op.second_vld = 1'b0;
		end
		push = accept && (lead_vld || tail_vld);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

`include "assert_macros.svh"

	`STT_ASSERT_NXT(a_eof_to_idle, accept && s_tuser, mode_q == MODE_IDLE)

endmodule

### hdl/stt_queue.sv
// Short queue of decoded transactions between front and back end
module stt_queue #(
	parameter int DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stt_pkg::tok_op_t wdata,
	output logic             full,
	input  logic             pop,
	output stt_pkg::tok_op_t rdata,
	output logic             empty
);
	import stt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	tok_op_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`include "assert_macros.svh"

	`STT_ASSERT(a_count_range, count_q <= CW'(DEPTH))
	`STT_ASSERT_IMP(a_no_overflow, push, !full)
	`STT_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

### hdl/stt_back.sv
// Back end: unpacks queued transactions into single result items on the output register
module stt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  stt_pkg::tok_op_t q_rdata,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [7:0] token_char
	output logic [4:0]       m_tuser,   // [3:0] token_kind, [4] char_present
	output logic             m_tlast
);
	import stt_pkg::*;

	tok_item_t cur_q, nxt_q;
	logic      cur_vld_q, nxt_vld_q;
	logic      m_fire;

	assign m_fire = m_tvalid && m_tready;
	assign q_pop  = !q_empty && (!cur_vld_q || (m_fire && !nxt_vld_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			nxt_vld_q <= 1'b0;
		end else if (q_pop) begin
			cur_vld_q <= 1'b1;
			nxt_vld_q <= q_rdata.second_vld;
		end else if (m_fire) begin
			cur_vld_q <= nxt_vld_q;
			nxt_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata.first;
			nxt_q <= q_rdata.second;
		end else if (m_fire && nxt_vld_q) begin
			cur_q <= nxt_q;
		end
	end

	assign m_tvalid = cur_vld_q;
	assign m_tdata  = cur_q.ch;
	assign m_tuser  = {cur_q.present, cur_q.kind};
	assign m_tlast  = cur_q.last;

`include "assert_macros.svh"

	`STT_ASSERT_IMP(a_nxt_needs_cur, nxt_vld_q, cur_vld_q)
	`STT_ASSERT_IMP(a_marker_is_last, cur_vld_q && !cur_q.present, cur_q.last)

endmodule

### hdl/source_text_tokenizer.sv
// A result item passes through the decoded-transaction queue and the output register to the master side.
// One byte is accepted per cycle while the queue is not full; a byte that closes a token and starts another,
// or an end of text that closes a token, gives two items, which the output register presents one after the other.
// The decoded-transaction queue (QUEUE_DEPTH entries) absorbs those bursts and output stalls.
// Reset (arst_n low, asynchronous): scan mode to idle, queue emptied, no output valid.
module source_text_tokenizer #(
	parameter int QUEUE_DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic       s_tuser,   // [0] cmd
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_char
	output logic [4:0] m_tuser,   // [3:0] token_kind, [4] char_present
	output logic       m_tlast    // token_end
);
	import stt_pkg::*;

	tok_op_t push_op, pop_op;
	logic    push, pop, q_full, q_empty;

	stt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.op       (push_op)
	);

	stt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_op),
		.full   (q_full),
		.pop    (pop),
		.rdata  (pop_op),
		.empty  (q_empty)
	);

	stt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_rdata  (pop_op),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### sim/tb_top.sv
// Testbench for the source text tokenizer: queued stream stimulus, inline token predictor, in-order check
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import stt_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1050;
	localparam int LONG_HOLD    = 300;
	localparam int CALM_TAIL    = 120;

	typedef struct packed {
		logic       eot;
		logic [7:0] text;
	} text_xfer_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] ch;
		logic       present;
		logic       last;
	} tok_exp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic       s_tuser = 1'b0;    // [0] cmd
	logic [7:0] s_tdata = 8'h00;   // [7:0] text_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] token_char
	logic [4:0] m_tuser;           // [3:0] token_kind, [4] char_present
	logic       m_tlast;           // token_end

	text_xfer_t text_q[$];
	tok_exp_t   token_q[$];
	text_xfer_t cur_xfer;
	mode_t      scan_state = MODE_IDLE;

	int  err_cnt = 0;
	int  sent_cnt = 0;
	int  got_cnt = 0;
	int  eot_cnt = 0;
	int  cyc_cnt = 0;
	int  tx_gap = 0;
	int  rx_hold = 0;
	int  hold_cyc = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;
	bit  long_hold_done = 1'b0;
	bit  long_hold_on = 1'b0;

	source_text_tokenizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit is_num(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction

	function automatic bit sym_kind(input logic [7:0] c, output kind_t k);
		k = KIND_EOF;
		case (c)
			CH_SEMI:  k = KIND_SEMI;
			CH_COMMA: k = KIND_COMMA;
			CH_EQ:    k = KIND_EQ;
			CH_LPAR:  k = KIND_LPAR;
			CH_RPAR:  k = KIND_RPAR;
			CH_LBRC:  k = KIND_LBRC;
			CH_RBRC:  k = KIND_RBRC;
			default:  k = KIND_EOF;
		endcase
		return k != KIND_EOF;
	endfunction

	task automatic push_tok(input kind_t k, input logic [7:0] ch, input logic p, input logic l);
		tok_exp_t e;
		e.kind    = k;
		e.ch      = ch;
		e.present = p;
		e.last    = l;
		token_q.push_back(e);
	endtask

	// expected token items for one accepted text transaction
	task automatic predict_tokens(input logic eot, input logic [7:0] c);
		kind_t pk;
		bit    rescan;
		rescan = 1'b0;
		if (eot) begin
			case (scan_state)
				MODE_INT: push_tok(KIND_INT, 8'h00, 1'b0, 1'b1);
				MODE_ID:  push_tok(KIND_ID, 8'h00, 1'b0, 1'b1);
				MODE_STR: push_tok(KIND_STR, 8'h00, 1'b0, 1'b1);
				default:  ;
			endcase
			push_tok(KIND_EOF, 8'h00, 1'b0, 1'b1);
			scan_state = MODE_IDLE;
		end else begin
			case (scan_state)
				MODE_INT: begin
					if (is_num(c)) push_tok(KIND_INT, c, 1'b1, 1'b0);
					else begin
						push_tok(KIND_INT, 8'h00, 1'b0, 1'b1);
						rescan = 1'b1;
					end
				end
				MODE_ID: begin
					if (is_num(c) || is_alpha(c)) push_tok(KIND_ID, c, 1'b1, 1'b0);
					else begin
						push_tok(KIND_ID, 8'h00, 1'b0, 1'b1);
						rescan = 1'b1;
					end
				end
				MODE_STR: begin
					if (c == CH_QUOTE) begin
						push_tok(KIND_STR, 8'h00, 1'b0, 1'b1);
						scan_state = MODE_IDLE;
					end else push_tok(KIND_STR, c, 1'b1, 1'b0);
				end
				default: rescan = 1'b1;
			endcase
			if (rescan) begin
				scan_state = MODE_IDLE;
				if (is_num(c)) begin
					scan_state = MODE_INT;
					push_tok(KIND_INT, c, 1'b1, 1'b0);
				end else if (is_alpha(c)) begin
					scan_state = MODE_ID;
					push_tok(KIND_ID, c, 1'b1, 1'b0);
				end else if (c == CH_QUOTE) begin
					scan_state = MODE_STR;
				end else if (sym_kind(c, pk)) begin
					push_tok(pk, c, 1'b1, 1'b1);
				end
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("mismatch: %s", msg);
	endtask

	task automatic add_byte(input logic [7:0] b);
		text_xfer_t x;
		x.eot  = 1'b0;
		x.text = b;
		text_q.push_back(x);
	endtask

	task automatic add_eot(input logic [7:0] junk);
		text_xfer_t x;
		x.eot  = 1'b1;
		x.text = junk;
		text_q.push_back(x);
		eot_cnt++;
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_byte(8'(s[i]));
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'(CH_0 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'(CH_UA + r) : 8'(CH_LA + r - 26);
	endfunction

	function automatic logic [7:0] rand_punct();
		logic [7:0] c;
		case ($urandom_range(0, 6))
			0: c = CH_SEMI;
			1: c = CH_COMMA;
			2: c = CH_EQ;
			3: c = CH_LPAR;
			4: c = CH_RPAR;
			5: c = CH_LBRC;
			default: c = CH_RBRC;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] rand_non_quote();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CH_QUOTE) c = 8'hA2;
		return c;
	endfunction

	// mostly well-formed tokens, some noise, occasional end of text
	task automatic add_random_token();
		int n;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 5) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++) add_byte(rand_digit());
		end else if (sel < 10) begin
			n = $urandom_range(0, 6);
			add_byte(rand_letter());
			for (int i = 0; i < n; i++)
				add_byte(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter());
		end else if (sel < 13) begin
			n = $urandom_range(0, 6);
			add_byte(CH_QUOTE);
			for (int i = 0; i < n; i++) add_byte(rand_non_quote());
			if ($urandom_range(0, 7) == 0) add_eot(8'($urandom_range(0, 255)));
			else add_byte(CH_QUOTE);
		end else if (sel < 15) begin
			add_byte(rand_punct());
		end else if (sel < 17) begin
			add_byte(($urandom_range(0, 1) == 0) ? 8'h20 : 8'h0A);
		end else if (sel < 19) begin
			add_byte(rand_non_quote());
		end else begin
			add_eot(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 1) == 0) begin
			case ($urandom_range(0, 2))
				0: add_byte(8'h20);
				1: add_byte(8'h0A);
				default: add_byte(rand_punct());
			endcase
		end
	endtask

	// sender: one transaction per handshake, random idle bursts
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			predict_tokens(cur_xfer.eot, cur_xfer.text);
			sent_cnt++;
		end
		if ($urandom_range(0, 99) == 0) tx_idle_on = !tx_idle_on;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (text_q.size() > CALM_TAIL && tx_idle_on && $urandom_range(0, 9) == 0) begin
				tx_gap = $urandom_range(0, 7);
				s_tvalid <= 1'b0;
			end else if (text_q.size() > 0) begin
				cur_xfer = text_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= cur_xfer.eot;
				s_tdata  <= cur_xfer.text;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// long output hold, counted on its own
	always @(posedge clk) begin
		if (!arst_n) begin
			long_hold_on <= 1'b0;
		end else if (long_hold_on) begin
			hold_cyc++;
			if (hold_cyc >= LONG_HOLD) long_hold_on <= 1'b0;
		end else if (!long_hold_done && got_cnt >= 400) begin
			long_hold_done = 1'b1;
			hold_cyc = 0;
			long_hold_on <= 1'b1;
		end
	end

	// receiver: in-order check against predicted token items, backpressure
	always @(posedge clk) begin
		tok_exp_t e;
		if (m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				report_mismatch($sformatf("unexpected token item %0d kind %0d char %02h",
					got_cnt, m_tuser[3:0], m_tdata));
			end else begin
				e = token_q.pop_front();
				if (m_tuser[3:0] !== e.kind)
					report_mismatch($sformatf("item %0d kind %0d, want %0d",
						got_cnt, m_tuser[3:0], e.kind));
				if (m_tdata !== e.ch)
					report_mismatch($sformatf("item %0d char %02h, want %02h",
						got_cnt, m_tdata, e.ch));
				if (m_tuser[4] !== e.present)
					report_mismatch($sformatf("item %0d char_present %0b, want %0b",
						got_cnt, m_tuser[4], e.present));
				if (m_tlast !== e.last)
					report_mismatch($sformatf("item %0d token_end %0b, want %0b",
						got_cnt, m_tlast, e.last));
			end
			got_cnt++;
		end
		if ($urandom_range(0, 99) == 0) rx_idle_on = !rx_idle_on;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold_on) begin
			m_tready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (text_q.size() > CALM_TAIL && rx_idle_on && $urandom_range(0, 7) == 0) begin
			rx_hold = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		while (cyc_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc_cnt++;
		end
		$display("timeout after %0d cycles", cyc_cnt);
		$display("[source_text_tokenizer] ERROR");
		$finish;
	end

	initial begin
		int target;
		// directed: class boundaries, token closed by letter and by punctuation
		add_text("09AzZa9{");
		add_text(";,=()}");
		// integer closed by space, skipped bytes
		add_text("5 ");
		add_byte(8'h00);
		add_byte(8'h0A);
		// empty string, then unterminated string closed at end of text
		add_text("\"\"");
		add_byte(CH_QUOTE);
		add_byte(8'hFF);
		add_eot(CH_QUOTE);
		// open identifier and integer at end of text, end of text from idle
		add_text("b");
		add_eot(8'hFF);
		add_text("7");
		add_eot(8'h00);
		add_eot(8'h5A);

		target = text_q.size() + RANDOM_ITEMS;
		while (text_q.size() < target) add_random_token();
		add_eot(8'h00);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_q.size() != 0 || s_tvalid) @(negedge clk);
		while (token_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("sent %0d text transactions (%0d end-of-text marks), checked %0d token items",
			sent_cnt, eot_cnt, got_cnt);
		$display("one output hold of %0d cycles with the input left running", LONG_HOLD);
		if (err_cnt == 0 && token_q.size() == 0) begin
			$display("[source_text_tokenizer] OK");
		end else begin
			$display("%0d mismatches, %0d items outstanding", err_cnt, token_q.size());
			$display("[source_text_tokenizer] ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/source_text_tokenizer.sv
sim/tb_top.sv
